// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for the concurrent assertions of the probe enumerator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define BSPE_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Assertion on the cycle that follows an active reset.
`define BSPE_ASSERT_RST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) !rstn |=> (prop)) else $error(msg);

`endif

// File: rtl/bspe_pkg.sv
// ----------------------------------------------------------------------------
// Bus slave probe enumerator package
// Types, codes and helpers shared by the enumerator modules.
// ----------------------------------------------------------------------------
package bspe_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HW_IDS       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HW_REVS      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SW_REVS      = 2'd3;

  // Probe stage codes.
  localparam logic [7:0] STAGE_RESET    = 8'd0;
  localparam logic [7:0] STAGE_PROBE    = 8'd1;
  localparam logic [7:0] STAGE_CONFIRM  = 8'd2;
  localparam logic [7:0] STAGE_ASSIGN   = 8'd3;
  localparam logic [7:0] STAGE_HOLD     = 8'd4;
  localparam logic [7:0] STAGE_ATTACH   = 8'd5;

  localparam logic [2:0] SLOT_ST_IDLE     = 3'd0;
  localparam logic [2:0] SLOT_ST_ASSIGNED = 3'd3;
  localparam logic [2:0] SLOT_ST_ATTACHED = 3'd5;

  localparam logic [7:0] HW_ATTACHED_FLAG = 8'h80;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BUSY,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [7:0]  code;
    logic [7:0]  stage;
    logic [7:0]  offer;
    logic [15:0] serial;
  } req_t;

  typedef struct packed {
    logic [2:0]  stage;
    logic [7:0]  addr;
    logic [15:0] serial;
  } slot_rec_t;

  typedef struct packed {
    logic        en;
    logic        store_pair;
    logic [2:0]  stage;
    logic [7:0]  addr;
    logic [15:0] serial;
  } slot_wr_t;

  typedef struct packed {
    logic        skip;
    logic        stop;
    logic        persist;
    logic [7:0]  r_addr;
    logic [15:0] r_serial;
    logic [7:0]  hw_id;
  } eval_t;

  typedef struct packed {
    logic        responded;
    logic [1:0]  slot_index;
    logic [7:0]  code;
    logic [7:0]  stage;
    logic [7:0]  address;
    logic [15:0] serial;
    logic [7:0]  hw_id;
    logic [7:0]  hw_rev;
    logic [7:0]  sw_rev;
    logic        persist;
  } result_t;

  // Byte of a packed per-slot word; slots 4 and above read zero.
  function automatic logic [7:0] get_byte(logic [31:0] word, logic [2:0] idx);
    logic [7:0] b;
    b = '0;
    case (idx)
      3'd0: b = word[7:0];
      3'd1: b = word[15:8];
      3'd2: b = word[23:16];
      3'd3: b = word[31:24];
      default: b = '0;
    endcase
    return b;
  endfunction

endpackage

// File: rtl/bspe_slot_store.sv
// ----------------------------------------------------------------------------
// Slot store
// Per-slot probe stage, assigned address and serial, one read and one write.
// ----------------------------------------------------------------------------
module bspe_slot_store import bspe_pkg::*; #(
  parameter int NUM_SLOTS = 4,
  parameter int SLOT_W    = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [SLOT_W-1:0] rd_idx,
  output slot_rec_t         rd_rec,
  input  logic [SLOT_W-1:0] wr_idx,
  input  slot_wr_t          wr
);

  logic [2:0]  stage_r  [NUM_SLOTS];
  logic [7:0]  addr_r   [NUM_SLOTS];
  logic [15:0] serial_r [NUM_SLOTS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        stage_r[i]  <= '0;
        addr_r[i]   <= '0;
        serial_r[i] <= '0;
      end
    end else if (wr.en) begin
      stage_r[wr_idx] <= wr.stage;
      if (wr.store_pair) begin
        addr_r[wr_idx]   <= wr.addr;
        serial_r[wr_idx] <= wr.serial;
      end
    end
  end

  assign rd_rec.stage  = stage_r[rd_idx];
  assign rd_rec.addr   = addr_r[rd_idx];
  assign rd_rec.serial = serial_r[rd_idx];

endmodule

// File: rtl/bspe_slot_eval.sv
// ----------------------------------------------------------------------------
// Slot evaluator
// Decides for one slot whether it skips, ends the scan or answers the request.
// ----------------------------------------------------------------------------
module bspe_slot_eval import bspe_pkg::*; (
  input  req_t       req,
  input  slot_rec_t  rec,
  input  logic [7:0] hw_id,
  output eval_t      res
);

  logic req_attach;
  logic slot_attached;
  logic ignored;
  logic pair_valid;
  logic premature;
  logic reattach;

  always_comb begin
    req_attach    = (req.stage == STAGE_ATTACH);
    slot_attached = (rec.stage == SLOT_ST_ATTACHED);
    ignored       = (req.stage == STAGE_HOLD) || (req.stage > STAGE_ATTACH);
    pair_valid    = (rec.addr != 8'd0) && (rec.serial != 16'd0);
    premature     = req_attach && (rec.stage < SLOT_ST_ASSIGNED) && !pair_valid;
    reattach      = ((req.stage == STAGE_PROBE) || (req.stage == STAGE_CONFIRM)) && pair_valid;

    // An attached slot only listens to attach requests.
    res.skip    = (slot_attached && !req_attach) || premature;
    res.stop    = !res.skip && ignored;
    res.persist = (req.stage == STAGE_ASSIGN);

    res.r_addr   = reattach ? rec.addr : req.offer;
    res.r_serial = reattach ? rec.serial : req.serial;
    res.hw_id    = (req_attach && slot_attached) ? (hw_id | HW_ATTACHED_FLAG) : hw_id;
  end

endmodule

// File: rtl/bus_slave_probe_enumerator.sv
// ----------------------------------------------------------------------------
// Bus slave probe enumerator
// Walks the slots in use for each probe request to bus address 0 and builds one response.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) takes one probe request item. The
//   output channel (out_valid/out_ready) gives exactly one result item for
//   each request; when no slot answers, every result field is zero.
//   Configuration registers are written through cfg_we/cfg_index/cfg_wdata
//   while the block is idle; the user must keep to this, the block does not enforce it.
//   A request to another address, or with no slot in use, goes straight to
//   the done state. Otherwise a stage-1 request first walks the slots for a
//   busy check and stops there if a slot in use is mid-probe; then the
//   request walks the slots until one answers or ends the scan, one slot per
//   cycle through the single slot evaluator. The result is registered from
//   the done state. in_ready is low during that walk and rises with the
//   registered result, so no new item is taken before the last is done.
//   If the receiver stalls, a finished result holds in the sequencer until
//   the output register frees, and in_ready stays low meanwhile.
//   Reset (synchronous, active low) clears all slot state, the configuration
//   registers and the output valid flag.
// ----------------------------------------------------------------------------
module bus_slave_probe_enumerator import bspe_pkg::*; #(
  parameter int NUM_SLOTS = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_bus_address,
  input  logic [7:0]            in_request_code,
  input  logic [7:0]            in_probe_stage,
  input  logic [7:0]            in_offered_address,
  input  logic [15:0]           in_controller_serial,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_responded,
  output logic [1:0]            out_slot_index,
  output logic [7:0]            out_resp_code,
  output logic [7:0]            out_resp_stage,
  output logic [7:0]            out_resp_address,
  output logic [15:0]           out_resp_serial,
  output logic [7:0]            out_resp_hw_id,
  output logic [7:0]            out_resp_hw_revision,
  output logic [7:0]            out_resp_sw_revision,
  output logic                  out_persist_request,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
  localparam logic [3:0] SLOTS_WIDE = 4'(NUM_SLOTS);

  // Configuration registers.
  logic [2:0]  dev_count_r;
  logic [31:0] hw_ids_r;
  logic [31:0] hw_revs_r;
  logic [31:0] sw_revs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_count_r <= '0;
      hw_ids_r    <= '0;
      hw_revs_r   <= '0;
      sw_revs_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEVICE_COUNT: dev_count_r <= cfg_wdata[2:0];
        CFG_HW_IDS:       hw_ids_r    <= cfg_wdata;
        CFG_HW_REVS:      hw_revs_r   <= cfg_wdata;
        CFG_SW_REVS:      sw_revs_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  state_t           state_r, state_nxt;
  req_t             req_r, req_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  result_t          res_r, res_nxt;
  logic             out_valid_r, out_valid_nxt;
  result_t          out_r;
  logic             out_load;

  logic [SLOT_W-1:0] slot_idx;
  logic [2:0]        slot_idx_wide;
  slot_rec_t         rec;
  slot_wr_t          wr;
  eval_t             ev;
  logic [7:0]        cur_hw_id;
  logic [3:0]        dev_wide;
  logic [CNT_W-1:0]  count_cap;
  logic              scan_end;
  logic              slot_busy;

  assign slot_idx      = idx_r[SLOT_W-1:0];
  assign slot_idx_wide = 3'(slot_idx);
  assign cur_hw_id     = get_byte(hw_ids_r, slot_idx_wide);
  assign dev_wide      = {1'b0, dev_count_r};
  assign count_cap     = (dev_wide > SLOTS_WIDE) ? CNT_W'(NUM_SLOTS) : CNT_W'(dev_wide);
  assign scan_end      = (idx_r == count_r);
  assign slot_busy     = (rec.stage != SLOT_ST_IDLE) && (rec.stage < SLOT_ST_ATTACHED);

  bspe_slot_store #(
    .NUM_SLOTS (NUM_SLOTS),
    .SLOT_W    (SLOT_W)
  ) u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_idx (slot_idx),
    .rd_rec (rec),
    .wr_idx (slot_idx),
    .wr     (wr)
  );

  bspe_slot_eval u_eval (
    .req   (req_r),
    .rec   (rec),
    .hw_id (cur_hw_id),
    .res   (ev)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r   <= req_nxt;
    count_r <= count_nxt;
    idx_r   <= idx_nxt;
    res_r   <= res_nxt;
    if (out_load) begin
      out_r <= res_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    req_nxt   = req_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    res_nxt   = res_r;
    wr        = '0;
    out_load  = 1'b0;
    in_ready  = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          req_nxt.code   = in_request_code;
          req_nxt.stage  = in_probe_stage;
          req_nxt.offer  = in_offered_address;
          req_nxt.serial = in_controller_serial;
          count_nxt      = count_cap;
          idx_nxt        = '0;
          res_nxt        = '0;
          if ((in_bus_address != 8'd0) || (count_cap == '0)) begin
            state_nxt = ST_DONE;
          end else if (in_probe_stage == STAGE_PROBE) begin
            state_nxt = ST_BUSY;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end

      // A new probe is refused while any slot in use is mid-probe.
      ST_BUSY: begin
        if (scan_end) begin
          idx_nxt   = '0;
          state_nxt = ST_SCAN;
        end else if (slot_busy) begin
          state_nxt = ST_DONE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      ST_SCAN: begin
        if (scan_end || ev.stop) begin
          state_nxt = ST_DONE;
        end else if (ev.skip) begin
          idx_nxt = idx_r + 1'b1;
        end else begin
          wr.en         = 1'b1;
          wr.store_pair = ev.persist;
          wr.stage      = req_r.stage[2:0];
          wr.addr       = req_r.offer;
          wr.serial     = req_r.serial;

          res_nxt.responded  = 1'b1;
          res_nxt.slot_index = 2'(slot_idx);
          res_nxt.code       = req_r.code;
          res_nxt.stage      = req_r.stage;
          res_nxt.address    = ev.r_addr;
          res_nxt.serial     = ev.r_serial;
          res_nxt.hw_id      = ev.hw_id;
          res_nxt.hw_rev     = get_byte(hw_revs_r, slot_idx_wide);
          res_nxt.sw_rev     = get_byte(sw_revs_r, slot_idx_wide);
          res_nxt.persist    = ev.persist;
          state_nxt          = ST_DONE;
        end
      end

      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_responded        = out_r.responded;
  assign out_slot_index       = out_r.slot_index;
  assign out_resp_code        = out_r.code;
  assign out_resp_stage       = out_r.stage;
  assign out_resp_address     = out_r.address;
  assign out_resp_serial      = out_r.serial;
  assign out_resp_hw_id       = out_r.hw_id;
  assign out_resp_hw_revision = out_r.hw_rev;
  assign out_resp_sw_revision = out_r.sw_rev;
  assign out_persist_request  = out_r.persist;

endmodule

// File: rtl/bspe_checker.sv
// ----------------------------------------------------------------------------
// Probe enumerator checker
// Port-level assertions on the enumerator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bspe_checker import bspe_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_responded,
  input logic [1:0]  out_slot_index,
  input logic [7:0]  out_resp_code,
  input logic [7:0]  out_resp_stage,
  input logic [7:0]  out_resp_address,
  input logic [15:0] out_resp_serial,
  input logic [7:0]  out_resp_hw_id,
  input logic        out_persist_request
);

  // A stalled result keeps its payload.
  `BSPE_ASSERT_CLK(a_out_hold, clk, rst_n,
    out_valid && !out_ready |=> out_valid && $stable(out_resp_serial) &&
    $stable(out_resp_address) && $stable(out_responded),
    "result changed while stalled")

  // A result without a response carries nothing else.
  `BSPE_ASSERT_CLK(a_no_resp_zero, clk, rst_n,
    out_valid && !out_responded |-> out_persist_request == 1'b0 &&
    out_resp_code == 8'd0 && out_resp_stage == 8'd0 && out_resp_hw_id == 8'd0 &&
    out_slot_index == 2'd0,
    "empty result carries data")

  // Only an address assignment asks for the pair to be saved.
  `BSPE_ASSERT_CLK(a_persist_stage, clk, rst_n,
    out_valid && out_persist_request |-> out_responded && out_resp_stage == STAGE_ASSIGN,
    "persist without assignment")

  // A taken item is never directly followed by another one.
  `BSPE_ASSERT_CLK(a_walk_busy, clk, rst_n, in_valid && in_ready |=> !in_ready,
    "new item taken during slot walk")

  `BSPE_ASSERT_RST(a_reset_empty, clk, rst_n, !out_valid, "result valid after reset")

endmodule

bind bus_slave_probe_enumerator bspe_checker u_bspe_checker (.*);
